// File: rtl/modexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_pkg: shared types, codes and microprogram for the modexp core
// Holds the control word layout, the step numbers and the read-only
// microprogram that sequences the square-and-multiply datapath.
// ----------------------------------------------------------------------------
package modexp_pkg;

    // Default word width of the core.
    localparam int WORD_BITS_DEF = 64;

    // Configuration register indexes.
    localparam logic CFG_MODULUS  = 1'b0;
    localparam logic CFG_EXPONENT = 1'b1;

    // Datapath operations carried in a control word.
    typedef enum logic [3:0] {
        OP_NOP     = 4'd0,
        OP_LOAD    = 4'd1,  // take base and exponent when start is seen
        OP_SET_RED = 4'd2,  // prepare reduction of the running base
        OP_SET_MUL = 4'd3,  // prepare result times running base
        OP_SET_SQR = 4'd4,  // prepare running base squared
        OP_STEP    = 4'd5,  // one bit of the shared modular unit
        OP_WB_RUN  = 4'd6,  // reduced base back into the running base
        OP_WB_RES  = 4'd7,  // product back into the result
        OP_WB_SQR  = 4'd8,  // square back into running base, next exponent bit
        OP_OUT     = 4'd9   // present the result
    } t_op;

    // Jump conditions.
    typedef enum logic [2:0] {
        JC_NEXT      = 3'd0,
        JC_ALWAYS    = 3'd1,
        JC_NOT_START = 3'd2,
        JC_CNT_MORE  = 3'd3,
        JC_EXP_ZERO  = 3'd4,
        JC_BIT_CLR   = 3'd5
    } t_cond;

    typedef logic [3:0] t_step;

    localparam t_step STEP_IDLE    = 4'd0;
    localparam t_step STEP_RED_SET = 4'd1;
    localparam t_step STEP_RED_RUN = 4'd2;
    localparam t_step STEP_RED_WB  = 4'd3;
    localparam t_step STEP_TST_Z   = 4'd4;
    localparam t_step STEP_TST_B   = 4'd5;
    localparam t_step STEP_MUL_SET = 4'd6;
    localparam t_step STEP_MUL_RUN = 4'd7;
    localparam t_step STEP_MUL_WB  = 4'd8;
    localparam t_step STEP_SQR_SET = 4'd9;
    localparam t_step STEP_SQR_RUN = 4'd10;
    localparam t_step STEP_SQR_WB  = 4'd11;
    localparam t_step STEP_DONE    = 4'd12;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_ctrl;

    // The microprogram. A step falls through to the next one unless its
    // condition holds, in which case it jumps to the target.
    function automatic t_ctrl ucode_rom(input t_step step);
        t_ctrl w;
        unique case (step)
            STEP_IDLE:    w = '{OP_LOAD,    JC_NOT_START, STEP_IDLE};
            STEP_RED_SET: w = '{OP_SET_RED, JC_NEXT,      STEP_IDLE};
            STEP_RED_RUN: w = '{OP_STEP,    JC_CNT_MORE,  STEP_RED_RUN};
            STEP_RED_WB:  w = '{OP_WB_RUN,  JC_NEXT,      STEP_IDLE};
            STEP_TST_Z:   w = '{OP_NOP,     JC_EXP_ZERO,  STEP_DONE};
            STEP_TST_B:   w = '{OP_NOP,     JC_BIT_CLR,   STEP_SQR_SET};
            STEP_MUL_SET: w = '{OP_SET_MUL, JC_NEXT,      STEP_IDLE};
            STEP_MUL_RUN: w = '{OP_STEP,    JC_CNT_MORE,  STEP_MUL_RUN};
            STEP_MUL_WB:  w = '{OP_WB_RES,  JC_NEXT,      STEP_IDLE};
            STEP_SQR_SET: w = '{OP_SET_SQR, JC_NEXT,      STEP_IDLE};
            STEP_SQR_RUN: w = '{OP_STEP,    JC_CNT_MORE,  STEP_SQR_RUN};
            STEP_SQR_WB:  w = '{OP_WB_SQR,  JC_ALWAYS,    STEP_TST_Z};
            STEP_DONE:    w = '{OP_OUT,     JC_ALWAYS,    STEP_IDLE};
            default:      w = '{OP_NOP,     JC_ALWAYS,    STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/modular_exponentiation_64_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_64_core: base ^ exponent mod modulus
// Right-to-left square and multiply, sequenced by a microprogram over one
// shared bit-serial modular multiply and reduce unit.
// ----------------------------------------------------------------------------
//
// Usage. Write the modulus (index 0) and the exponent (index 1) through the
// configuration port while the core is idle; both take effect at once and
// reset to a modulus of one and an exponent of zero. A base word is taken
// by a transfer at a clock edge where start is high and busy is low. The
// result appears on o_power, marked by o_valid for exactly one cycle; the
// receiver cannot stall it, so it must take the word in that cycle.
//
// Operation. The core first reduces the base modulo the modulus, then walks
// the exponent from its least significant bit up to its highest set bit.
// The time an item takes grows with WORD_BITS and with the bit length and
// the number of set bits of the exponent; it is set by the modular unit,
// which retires one multiplier bit per cycle. Items are handled one at a
// time; busy is high from the transfer until the result is presented.
// After reset the core is idle and ready at once; no result is pending.
//
module modular_exponentiation_64_core
    import modexp_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [WORD_BITS-1:0] i_cfg_data,
    // command channel
    input  logic                 start,
    output logic                 busy,
    input  logic [WORD_BITS-1:0] i_base,
    // result channel
    output logic                 o_valid,
    output logic [WORD_BITS-1:0] o_power
);

    localparam int CNT_BITS = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

    // Configuration registers.
    logic [WORD_BITS-1:0] r_mod;
    logic [WORD_BITS-1:0] r_exp_cfg;

    // Sequencer.
    t_step r_step;
    t_step n_step;
    t_ctrl w_ctrl;
    logic  w_jump;

    // Datapath registers.
    logic [WORD_BITS-1:0] r_run;   // running base
    logic [WORD_BITS-1:0] r_res;   // running result
    logic [WORD_BITS-1:0] r_exp;   // remaining exponent bits
    logic [WORD_BITS-1:0] r_a;     // addend operand, always reduced
    logic [WORD_BITS-1:0] r_b;     // multiplier operand, shifted out MSB first
    logic [WORD_BITS-1:0] r_acc;   // partial remainder
    logic                 r_red;   // unit reduces r_b rather than multiplying
    logic [CNT_BITS-1:0]  r_cnt;
    logic                 r_valid;
    logic [WORD_BITS-1:0] r_power;

    // One step of the modular unit.
    logic                 w_use_mod;
    logic [WORD_BITS:0]   w_dbl;
    logic [WORD_BITS:0]   w_dbl_s;
    logic [WORD_BITS:0]   w_sum;
    logic [WORD_BITS:0]   w_sum_s;
    logic [WORD_BITS-1:0] w_acc_next;

    assign busy    = (r_step != STEP_IDLE);
    assign o_valid = r_valid;
    assign o_power = r_power;

    // ------------------------------------------------------------------
    // Configuration. Writes land at once; the port has no handshake.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod     <= WORD_BITS'(1);
            r_exp_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODULUS:  r_mod     <= i_cfg_data;
                CFG_EXPONENT: r_exp_cfg <= i_cfg_data;
                default:      r_mod     <= r_mod;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: fetch the control word of the current step, evaluate its
    // jump condition and move to the target or to the following step.
    // ------------------------------------------------------------------
    assign w_ctrl = ucode_rom(r_step);

    always_comb begin
        unique case (w_ctrl.cond)
            JC_NEXT:      w_jump = 1'b0;
            JC_ALWAYS:    w_jump = 1'b1;
            JC_NOT_START: w_jump = !start;
            JC_CNT_MORE:  w_jump = (r_cnt != CNT_LAST);
            JC_EXP_ZERO:  w_jump = (r_exp == '0);
            JC_BIT_CLR:   w_jump = !r_exp[0];
            default:      w_jump = 1'b1;
        endcase
        n_step = w_jump ? w_ctrl.target : t_step'(r_step + 4'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= STEP_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_valid <= (w_ctrl.op == OP_OUT);
        end
    end

    // ------------------------------------------------------------------
    // Modular unit. Each step doubles the partial remainder; when reducing it
    // brings in the next bit of r_b, and when multiplying and that bit is set
    // it adds the reduced operand r_a. Both sums stay below twice the modulus,
    // so one conditional subtraction each keeps the remainder reduced. A zero
    // modulus skips the subtractions and everything wraps to the word.
    // ------------------------------------------------------------------
    always_comb begin
        w_use_mod = (r_mod != '0);
        w_dbl     = {r_acc, r_red & r_b[WORD_BITS-1]};
        w_dbl_s   = (w_use_mod && (w_dbl >= {1'b0, r_mod})) ?
                    (w_dbl - {1'b0, r_mod}) : w_dbl;
        w_sum     = {1'b0, w_dbl_s[WORD_BITS-1:0]} + {1'b0, r_a};
        w_sum_s   = (w_use_mod && (w_sum >= {1'b0, r_mod})) ?
                    (w_sum - {1'b0, r_mod}) : w_sum;
        w_acc_next = (!r_red && r_b[WORD_BITS-1]) ? w_sum_s[WORD_BITS-1:0]
                                                   : w_dbl_s[WORD_BITS-1:0];
    end

    // ------------------------------------------------------------------
    // Datapath, driven by the operation field of the control word.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (w_ctrl.op)
            OP_LOAD: begin
                if (start) begin
                    r_run <= i_base;
                    r_exp <= r_exp_cfg;
                    r_res <= WORD_BITS'(1);
                end
            end
            OP_SET_RED: begin
                r_a   <= '0;
                r_b   <= r_run;
                r_acc <= '0;
                r_red <= 1'b1;
                r_cnt <= '0;
            end
            OP_SET_MUL: begin
                r_a   <= r_run;
                r_b   <= r_res;
                r_acc <= '0;
                r_red <= 1'b0;
                r_cnt <= '0;
            end
            OP_SET_SQR: begin
                r_a   <= r_run;
                r_b   <= r_run;
                r_acc <= '0;
                r_red <= 1'b0;
                r_cnt <= '0;
            end
            OP_STEP: begin
                r_acc <= w_acc_next;
                r_b   <= {r_b[WORD_BITS-2:0], 1'b0};
                r_cnt <= r_cnt + CNT_BITS'(1);
            end
            OP_WB_RUN: r_run <= r_acc;
            OP_WB_RES: r_res <= r_acc;
            OP_WB_SQR: begin
                r_run <= r_acc;
                r_exp <= {1'b0, r_exp[WORD_BITS-1:1]};
            end
            OP_OUT:  r_power <= r_res;
            OP_NOP:  r_acc   <= r_acc;
            default: r_acc   <= r_acc;
        endcase
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer accepted but the core did not go busy");

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe lasted more than one cycle");

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_step) == STEP_DONE))
        else $error("result strobe without a completed item");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_step <= STEP_DONE))
        else $error("sequencer left the microprogram");

endmodule

// File: verif/modexp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_checker: result predictor and scoreboard for the modexp core
// Tracks the modulus and exponent registers from the write port, predicts
// base ^ exponent mod modulus for every accepted base, and compares each
// strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module modexp_checker
    import modexp_pkg::*;
#(
    parameter int W = WORD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [W-1:0] i_cfg_data,
    input  logic         i_start,
    input  logic         i_busy,
    input  logic [W-1:0] i_base,
    input  logic         i_valid,
    input  logic [W-1:0] i_power,
    output int           o_mismatches,
    output int           o_pending
);

    typedef logic [W-1:0] t_word;

    t_word modulus_r  = t_word'(1);
    t_word exponent_r = '0;
    t_word power_q[$];
    int    mismatches = 0;
    int    outstanding = 0;

    assign o_mismatches = mismatches;
    assign o_pending    = outstanding;

    // Exact double-width product reduced by the modulus. A zero modulus
    // means the product simply wraps to the word.
    function automatic t_word mul_mod(input t_word a, input t_word b, input t_word m);
        logic [2*W-1:0] prod;
        prod = {{W{1'b0}}, a} * {{W{1'b0}}, b};
        if (m != '0) begin
            prod = prod % {{W{1'b0}}, m};
        end
        return prod[W-1:0];
    endfunction

    // Right-to-left square and multiply. A zero exponent leaves the result at
    // one without any reduction.
    function automatic t_word raise_mod(input t_word b, input t_word e, input t_word m);
        t_word acc;
        t_word run;
        t_word rest;
        acc  = t_word'(1);
        run  = b;
        rest = e;
        while (rest != '0) begin
            if (rest[0]) begin
                acc = mul_mod(acc, run, m);
            end
            run  = mul_mod(run, run, m);
            rest = rest >> 1;
        end
        return acc;
    endfunction

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        mismatches++;
        $display("[%0t] power check: %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_word want;
        if (!i_rst_n) begin
            modulus_r  = t_word'(1);
            exponent_r = '0;
            power_q.delete();
        end else begin
            if (i_valid) begin
                if (power_q.size() == 0) begin
                    report_mismatch("result with nothing outstanding", i_power, '0);
                end else begin
                    want = power_q.pop_front();
                    if (i_power !== want) begin
                        report_mismatch("wrong power", i_power, want);
                    end
                end
            end
            if (i_start && !i_busy) begin
                power_q.push_back(raise_mod(i_base, exponent_r, modulus_r));
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MODULUS) begin
                    modulus_r = i_cfg_data;
                end else begin
                    exponent_r = i_cfg_data;
                end
            end
        end
        outstanding <= power_q.size();
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for modular_exponentiation_64_core
// Drives directed and random base words under a sequence of modulus and
// exponent settings, with bursty command traffic, and leaves prediction and
// comparison to the checker instantiated beside the core.
// ----------------------------------------------------------------------------
module tb_top;
    import modexp_pkg::*;

    localparam int W = WORD_BITS_DEF;

    // The slowest item is the one with all 64 exponent bits set. The stimulus
    // uses full-width exponents for only a couple of dozen items, so a correct
    // run ends well before the limit even with the longest sender pauses.
    localparam int CYCLE_LIMIT  = 10_000_000;
    // Quiet time after the last result, longer than a worst-case item, so
    // that any stray extra result is still seen by the checker.
    localparam int DRAIN_CYCLES = 9_000;
    localparam int RANDOM_PHASES = 12;

    typedef logic [W-1:0] t_word;

    logic  i_clk      = 1'b0;
    logic  i_rst_n    = 1'b0;
    logic  i_cfg_we   = 1'b0;
    logic  i_cfg_idx  = CFG_MODULUS;
    t_word i_cfg_data = '0;
    logic  start      = 1'b0;
    logic  busy;
    t_word i_base     = '0;
    logic  o_valid;
    t_word o_power;

    int mismatches;
    int pending;
    int cycle_count = 0;

    // Sender pacing: items go out in bursts, and a pause follows each burst
    // while gaps_on is set.
    int burst_left = 0;
    bit gaps_on    = 1'b1;

    always #2 i_clk = ~i_clk;

    modular_exponentiation_64_core #(
        .WORD_BITS (W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .start      (start),
        .busy       (busy),
        .i_base     (i_base),
        .o_valid    (o_valid),
        .o_power    (o_power)
    );

    modexp_checker #(
        .W (W)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_start      (start),
        .i_busy       (busy),
        .i_base       (i_base),
        .i_valid      (o_valid),
        .i_power      (o_power),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // Watchdog: a hung core or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[modular_exponentiation_64_core] ERROR");
            $finish;
        end
    end

    function automatic t_word rand_word();
        return {$urandom, $urandom};
    endfunction

    // Moduli of several shapes: full random, tiny, all ones, powers of two
    // and random widths. A zero pick is replaced by one.
    function automatic t_word pick_modulus();
        t_word m;
        case ($urandom_range(0, 4))
            0: m = rand_word();
            1: m = t_word'($urandom_range(1, 1000));
            2: m = '1;
            3: m = t_word'(1) << $urandom_range(0, W - 1);
            default: m = rand_word() >> $urandom_range(1, W - 1);
        endcase
        if (m == '0) begin
            m = t_word'(1);
        end
        return m;
    endfunction

    // Bases are reduced by the core before the first product, and values at
    // and above the modulus are deliberately common.
    function automatic t_word pick_base(input t_word m);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return m;
            3: return m - 1'b1;
            4: return t_word'($urandom_range(0, 15));
            default: return rand_word();
        endcase
    endfunction

    // One register write, set up on a falling edge and taken at the rising
    // edge that follows.
    task automatic write_reg(input logic idx, input t_word value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Present one base word and hold it until the core takes it. Start is
    // left high afterwards, so a following item in the same burst keeps it
    // high without a dip. A pause drops start for a random stretch; long
    // pauses let the next transfer land anywhere in the core's work.
    task automatic send_base(input t_word b);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 2500);
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(1, 5);
        end
        @(negedge i_clk);
        start  <= 1'b1;
        i_base <= b;
        // Busy is sampled at the rising edge, before the core updates it.
        do @(posedge i_clk); while (busy);
        if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    // Stop sending and wait until every predicted result has come back and
    // the core is idle again. Every item yields a result, so no extra
    // latency allowance is needed before reconfiguring.
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0 || busy) @(negedge i_clk);
    endtask

    task automatic configure(input t_word m, input t_word e);
        settle();
        write_reg(CFG_MODULUS, m);
        write_reg(CFG_EXPONENT, e);
    endtask

    initial begin
        t_word m;
        t_word e;
        bit    wide;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Out of reset the modulus is one and the exponent
        // zero: the result must be one, unreduced, whatever the base.
        send_base('0);
        send_base('1);
        send_base(t_word'(1));

        // A modulus of one with a nonzero exponent gives zero.
        configure(t_word'(1), t_word'(7));
        send_base('1);
        send_base(t_word'(5));

        // Both registers at their maximum: the longest possible item, with
        // every exponent bit set.
        configure('1, '1);
        send_base('0);
        send_base(t_word'(1));
        send_base('1);
        send_base({(W/2){2'b10}});
        send_base({(W/2){2'b01}});

        // Exponent one with a base above the modulus: the core reduces it before
        // the single multiply.
        configure(t_word'(1) << (W - 1), t_word'(1));
        send_base('1);
        send_base('0);

        // Large prime modulus with only the top exponent bit set, so the
        // core squares 63 times before its one multiply.
        configure('1 - t_word'(58), t_word'(1) << (W - 1));
        send_base(t_word'(2));
        send_base('1);

        // Zero exponent with an ordinary modulus, then a plain square.
        configure(t_word'(1000), '0);
        send_base('1);
        configure(t_word'(1000), t_word'(2));
        send_base('1);

        // Random part. Most phases use short exponents to keep items fast;
        // about one in four uses a full-width exponent with few items so the
        // upper exponent bits are exercised too. Some phases send back to
        // back with no pauses at all.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            m    = pick_modulus();
            wide = ($urandom_range(0, 3) == 0);
            if (wide) begin
                e = rand_word() | (t_word'(1) << (W - 1));
            end else begin
                e = rand_word() >> (W - $urandom_range(0, 16));
            end
            configure(m, e);
            gaps_on    = ($urandom_range(0, 2) != 0);
            burst_left = 0;
            repeat (wide ? 3 : 13) send_base(pick_base(m));
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending == 0) begin
            $display("[modular_exponentiation_64_core] OK");
        end else begin
            $display("[modular_exponentiation_64_core] ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/modexp_pkg.sv
rtl/modular_exponentiation_64_core.sv
verif/modexp_checker.sv
verif/tb_top.sv
